// ===== rtl/qpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder package
// Shared character codes, escape phase codes and the bundle type that
// carries the results of one input byte from the front end to the back end.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // Character codes used by the decoder.
  localparam logic [7:0] CH_EQ     = 8'h3D;  // '='
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF     = 8'h46;  // 'F'
  localparam logic [7:0] CH_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF_HEX = 8'h66;  // 'f'
  // Offsets that map a letter digit straight to its value ('A' + 10 rule).
  localparam logic [7:0] CH_UA_OFF = CH_UA - 8'd10;
  localparam logic [7:0] CH_LA_OFF = CH_LA - 8'd10;

  // Escape phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;  // no escape pending
  localparam logic [1:0] PH_EQ   = 2'd1;  // equals sign seen
  localparam logic [1:0] PH_HELD = 2'd2;  // equals sign and one byte seen

  // Results that one input byte can cause.
  localparam int unsigned MaxResults = 3;

  // Bundle queue depth.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Results of one input beat: cnt entries in bytes, the last one possibly
  // flagged as end of text; marker means a single entry with no byte.
  typedef struct packed {
    logic [1:0]                   cnt;
    logic                         marker;
    logic                         last;
    logic [MaxResults-1:0][7:0]   bytes;
  } qpd_bundle_t;

endpackage

// ===== rtl/qpd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder front end
// Accepts one encoded byte per beat, tracks the escape phase and builds the
// bundle of decoded bytes that the beat causes.
// ----------------------------------------------------------------------------
module qpd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output qpd_pkg::qpd_bundle_t q_data_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;
  logic [4:0] hi_val, lo_val;
  logic [1:0] n;
  logic [qpd_pkg::MaxResults-1:0][7:0] ent;
  logic       marker;

  // Digit value in the low four bits, bit four set when not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= qpd_pkg::CH_0 && b <= qpd_pkg::CH_9) begin
      d = b - qpd_pkg::CH_0;
      return {1'b0, d[3:0]};
    end
    if (b >= qpd_pkg::CH_UA && b <= qpd_pkg::CH_UF) begin
      d = b - qpd_pkg::CH_UA_OFF;
      return {1'b0, d[3:0]};
    end
    if (b >= qpd_pkg::CH_LA && b <= qpd_pkg::CH_LF_HEX) begin
      d = b - qpd_pkg::CH_LA_OFF;
      return {1'b0, d[3:0]};
    end
    return 5'h10;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign hi_val     = hex_value(held_q);
  assign lo_val     = hex_value(in_byte_i);

  // Classify the byte against the escape phase and collect the results.
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    n       = 2'd0;
    ent     = '0;
    marker  = 1'b0;
    if (phase_q == qpd_pkg::PH_HELD) begin
      phase_d = qpd_pkg::PH_IDLE;
      if (!hi_val[4] && !lo_val[4]) begin
        ent[0] = {hi_val[3:0], lo_val[3:0]};
        n      = 2'd1;
      end else if (held_q == qpd_pkg::CH_CR && in_byte_i == qpd_pkg::CH_LF) begin
        n = 2'd0;
      end else begin
        // Failed escape: pass the equals sign and rescan both bytes.
        ent[0] = qpd_pkg::CH_EQ;
        n      = 2'd1;
        if (held_q == qpd_pkg::CH_EQ) begin
          phase_d = qpd_pkg::PH_EQ;
        end else begin
          ent[1] = held_q;
          n      = 2'd2;
        end
        if (phase_d == qpd_pkg::PH_EQ) begin
          held_d  = in_byte_i;
          phase_d = qpd_pkg::PH_HELD;
        end else if (in_byte_i == qpd_pkg::CH_EQ) begin
          phase_d = qpd_pkg::PH_EQ;
        end else begin
          ent[2] = in_byte_i;
          n      = 2'd3;
        end
      end
    end else if (phase_q == qpd_pkg::PH_EQ) begin
      held_d  = in_byte_i;
      phase_d = qpd_pkg::PH_HELD;
    end else if (in_byte_i == qpd_pkg::CH_EQ) begin
      phase_d = qpd_pkg::PH_EQ;
    end else begin
      ent[0]  = in_byte_i;
      n       = 2'd1;
      phase_d = qpd_pkg::PH_IDLE;
    end

    // End of text flushes a pending escape literally.
    if (in_last_i) begin
      if (phase_d == qpd_pkg::PH_EQ) begin
        ent[n] = qpd_pkg::CH_EQ;
        n      = n + 2'd1;
      end else if (phase_d == qpd_pkg::PH_HELD) begin
        ent[n]         = qpd_pkg::CH_EQ;
        ent[n + 2'd1]  = held_d;
        n              = n + 2'd2;
      end
      phase_d = qpd_pkg::PH_IDLE;
      if (n == 2'd0) begin
        marker = 1'b1;
        n      = 2'd1;
      end
    end
  end

  assign q_push_o        = accept && (n != 2'd0);
  assign q_data_o.cnt    = n;
  assign q_data_o.marker = marker;
  assign q_data_o.last   = in_last_i;
  assign q_data_o.bytes  = ent;

  // Escape phase register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qpd_pkg::PH_IDLE;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  // Held byte; only read after it has been written.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== rtl/qpd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder bundle queue
// Short first-in first-out buffer of result bundles between the front end
// and the back end.
// ----------------------------------------------------------------------------
module qpd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  qpd_pkg::qpd_bundle_t push_data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 not_empty_o,
  output qpd_pkg::qpd_bundle_t head_o
);

  localparam logic [qpd_pkg::QueuePtrW:0] DepthCnt =
      (qpd_pkg::QueuePtrW + 1)'(qpd_pkg::QueueDepth);

  qpd_pkg::qpd_bundle_t           mem_q [qpd_pkg::QueueDepth];
  logic [qpd_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [qpd_pkg::QueuePtrW:0]    count_q;

  assign full_o      = (count_q == DepthCnt);
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Bundle storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/qpd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder back end
// Walks through the head bundle and presents its entries one beat at a time.
// ----------------------------------------------------------------------------
module qpd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_not_empty_i,
  input  qpd_pkg::qpd_bundle_t q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 byte_valid_o,
  output logic                 out_last_o
);

  logic [1:0] idx_q;
  logic       final_entry;
  logic       taken;

  assign final_entry  = (idx_q == q_head_i.cnt - 2'd1);
  assign out_valid_o  = q_not_empty_i;
  assign taken        = q_not_empty_i && !out_stall_i;
  assign q_pop_o      = taken && final_entry;
  assign out_byte_o   = q_head_i.marker ? 8'd0 : q_head_i.bytes[idx_q];
  assign byte_valid_o = !q_head_i.marker;
  assign out_last_o   = q_head_i.last && final_entry;

  // Entry index within the head bundle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (taken) begin
      idx_q <= final_entry ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/quoted_printable_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder unit
// Decodes a quoted-printable byte stream into plain bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one encoded byte per beat (in_byte_i, in_last_i
//   marking the final byte of a text). An item is accepted on a rising edge
//   with in_valid_i high and in_stall_o low.
//   The output channel gives one decoded byte per beat; byte_valid_o low
//   marks an end-of-text marker with no byte, and out_last_o flags the final
//   result of a text. A beat is taken when out_valid_o is high and
//   out_stall_i is low.
//   The results of an item are registered in the bundle queue before they
//   reach the output. Throughput: one item per cycle while each item gives
//   at most one result and the receiver does not stall; an item that gives
//   two or three results (a failed escape or an end-of-text flush) holds the
//   output while the back end emits one entry per cycle. A two-bundle queue
//   parts the front end from the back end.
//   Reset clears the escape phase and empties the queue. When the receiver
//   stalls, the presented beat holds; the queue fills and then in_stall_o
//   rises until room frees up.
// ----------------------------------------------------------------------------
module quoted_printable_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       out_last_o
);

  logic                 q_full, q_push, q_pop, q_not_empty;
  qpd_pkg::qpd_bundle_t q_push_data, q_head;

  // Byte classification and escape tracking.
  qpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // Bundle queue.
  qpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .head_o      (q_head)
  );

  // Result serialization.
  qpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .out_last_o    (out_last_o)
  );

endmodule

// ===== rtl/qpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder port checker
// Concurrent assertions on the port behavior of the decoder unit.
// ----------------------------------------------------------------------------
module qpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       out_last_o
);

  // A stalled input beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(in_byte_i) && $stable(in_last_i))
    else $error("stalled input beat changed");

  // A stalled output beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(byte_valid_o) && $stable(out_last_o))
    else $error("stalled output beat changed");

  // A marker beat carries no byte and always ends the text.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_last_o && (out_byte_o == 8'd0))
    else $error("marker beat without end of text");

  // Output becomes valid only after an input beat was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output appeared without an accepted input");

  // Input stall rises only when a beat was just accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted input");

endmodule

bind quoted_printable_decoder_unit qpd_checker u_qpd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .in_byte_i    (in_byte_i),
  .in_last_i    (in_last_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_byte_o   (out_byte_o),
  .byte_valid_o (byte_valid_o),
  .out_last_o   (out_last_o)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted-printable decoder unit testbench
// Feeds encoded texts into the decoder one byte per beat and compares every
// decoded beat with a cycle-free model of the decoder kept in this file.
// Directed texts cover hex escapes in both cases, soft line breaks, failed
// escapes and end-of-text flushes. Random texts follow: plain bytes, hex
// escapes, soft breaks and malformed escapes with random content, and some
// noise. Both sides idle at random, the receiver holds off once for a long
// stretch, and the sender pauses until the decoder has drained.
// ----------------------------------------------------------------------------
module testbench;

  // One encoded byte to send, or a marker that holds the sender until drained.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
    logic [4:0] gap;
  } text_beat_t;

  // One decoded beat as the output channel presents it.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } plain_beat_t;

  localparam int unsigned HoldAtItem  = 40;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned TailCycles  = 10;
  localparam int unsigned TotalItems  = 180;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       in_last_i   = 1'b0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       out_last_o;

  text_beat_t  send_q[$];
  plain_beat_t decoded_q[$];
  logic [7:0]  text_buf[$];

  int errors    = 0;
  int items_in  = 0;
  int beats_out = 0;
  int markers   = 0;
  int texts     = 0;
  int queued    = 0;
  int tx_max    = 0;

  // Model state of the decoder.
  logic [1:0]  esc_phase = qpd_pkg::PH_IDLE;
  logic [7:0]  held_byte = 8'h00;
  plain_beat_t step_res[qpd_pkg::MaxResults];
  int          step_cnt;

  quoted_printable_decoder_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hex digit value in the low nibble; bit 4 set when c is not a digit.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h10;
    if (c >= qpd_pkg::CH_0 && c <= qpd_pkg::CH_9) v = c - qpd_pkg::CH_0;
    else if (c >= qpd_pkg::CH_UA && c <= qpd_pkg::CH_UF) v = c - qpd_pkg::CH_UA_OFF;
    else if (c >= qpd_pkg::CH_LA && c <= qpd_pkg::CH_LF_HEX) v = c - qpd_pkg::CH_LA_OFF;
    return v[4:0];
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    if (step_cnt < qpd_pkg::MaxResults) begin
      step_res[step_cnt] = {b, 1'b1, 1'b0};
      step_cnt++;
    end
  endtask

  // A byte seen from the idle or equals-seen phase.
  task automatic take_plain(input logic [7:0] b);
    if (esc_phase == qpd_pkg::PH_EQ) begin
      held_byte = b;
      esc_phase = qpd_pkg::PH_HELD;
    end else if (b == qpd_pkg::CH_EQ) begin
      esc_phase = qpd_pkg::PH_EQ;
    end else begin
      esc_phase = qpd_pkg::PH_IDLE;
      emit_byte(b);
    end
  endtask

  // Works out the decoded beats of one accepted input byte.
  task automatic decode_beat(input logic [7:0] b, input logic last);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] c1;
    step_cnt = 0;
    if (esc_phase == qpd_pkg::PH_HELD) begin
      c1 = held_byte;
      hi = digit_value(c1);
      lo = digit_value(b);
      esc_phase = qpd_pkg::PH_IDLE;
      if (!hi[4] && !lo[4]) begin
        emit_byte({hi[3:0], lo[3:0]});
      end else if (!(c1 == qpd_pkg::CH_CR && b == qpd_pkg::CH_LF)) begin
        // Failed escape: the equals sign goes out and both bytes are rescanned.
        emit_byte(qpd_pkg::CH_EQ);
        take_plain(c1);
        take_plain(b);
      end
    end else begin
      if (esc_phase != qpd_pkg::PH_EQ) esc_phase = qpd_pkg::PH_IDLE;
      take_plain(b);
    end
    if (last) begin
      // End of text flushes whatever escape is still pending.
      if (esc_phase == qpd_pkg::PH_EQ) begin
        emit_byte(qpd_pkg::CH_EQ);
      end else if (esc_phase == qpd_pkg::PH_HELD) begin
        emit_byte(qpd_pkg::CH_EQ);
        emit_byte(held_byte);
      end
      esc_phase = qpd_pkg::PH_IDLE;
      if (step_cnt == 0) begin
        step_res[0] = {8'h00, 1'b0, 1'b1};
        step_cnt = 1;
      end else begin
        step_res[step_cnt-1].last = 1'b1;
      end
    end
    for (int i = 0; i < step_cnt; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    text_beat_t t;
    t.data  = b;
    t.last  = last;
    t.drain = 1'b0;
    t.gap   = 5'($urandom_range(0, tx_max));
    send_q.insert(send_q.size(), t);
    queued++;
  endtask

  task automatic push_drain();
    text_beat_t t;
    t = '0;
    t.drain = 1'b1;
    send_q.insert(send_q.size(), t);
  endtask

  task automatic push_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      push_byte(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
    texts++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
    push_text();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return qpd_pkg::CH_0 + 8'(v);
    return (upper ? qpd_pkg::CH_UA_OFF : qpd_pkg::CH_LA_OFF) + 8'(v);
  endfunction

  function automatic logic [7:0] non_eq_byte(input logic printable);
    logic [7:0] b;
    b = printable ? 8'($urandom_range(32, 126)) : 8'($urandom);
    if (b == qpd_pkg::CH_EQ) b = qpd_pkg::CH_EQ + 8'd1;
    return b;
  endfunction

  // Appends one byte to the text under construction.
  task automatic add_char(input logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  // A random text built from plain bytes and escape tokens, sometimes cut short.
  task automatic gen_text();
    int tokens;
    tokens = $urandom_range(1, 5);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_char(non_eq_byte(1'b1));
        3: add_char(non_eq_byte(1'b0));
        4, 5: begin
          add_char(qpd_pkg::CH_EQ);
          add_char(hex_char(4'($urandom), 1'($urandom)));
          add_char(hex_char(4'($urandom), 1'($urandom)));
        end
        6: begin
          add_char(qpd_pkg::CH_EQ);
          add_char(qpd_pkg::CH_CR);
          add_char(qpd_pkg::CH_LF);
        end
        7: begin
          add_char(qpd_pkg::CH_EQ);
          add_char(8'($urandom));
          add_char(8'($urandom));
        end
        8: begin
          add_char(qpd_pkg::CH_EQ);
          add_char(qpd_pkg::CH_CR);
          add_char(8'($urandom));
        end
        default: add_char(qpd_pkg::CH_EQ);
      endcase
    end
    if (text_buf.size() > 1 && $urandom_range(0, 3) == 0) text_buf.delete(text_buf.size() - 1);
    push_text();
  endtask

  task automatic gen_noise();
    int len;
    len = $urandom_range(1, 6);
    repeat (len) add_char(8'($urandom));
    push_text();
  endtask

  task automatic gen_random_texts(input int upto);
    while (queued < upto) begin
      if ($urandom_range(0, 6) == 0) gen_noise();
      else gen_text();
    end
  endtask

  // Stimulus plan and end of run.
  initial begin
    // Directed texts; octal escapes stand for CR and LF.
    tx_max = 19;
    push_str("A");
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_str("=41");
    push_str("=4a");
    push_str("=\015\012");
    push_str("=G1");
    push_str("==41");
    push_str("=");
    push_str("=F");
    push_str("=\015X");
    push_str("=fF");
    push_drain();

    // Back-to-back texts while the receiver holds off.
    tx_max = 0;
    gen_random_texts(85);
    push_drain();

    // Texts with random sender gaps.
    tx_max = 19;
    gen_random_texts(145);
    push_drain();

    // Mixed gaps, chosen per text.
    while (queued < TotalItems) begin
      tx_max = $urandom_range(0, 1) ? 19 : 0;
      gen_random_texts(queued + 1);
    end

    wait (rst_ni);
    while (send_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d bytes in %0d texts; checked %0d decoded beats, %0d end markers.",
             items_in, texts, beats_out, markers);
    $display("Covered escapes, soft breaks, failed escapes, flushes and back-pressure.");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d bytes unsent and %0d beats outstanding.",
             send_q.size(), decoded_q.size());
    $display("testbench NOT OK");
    $finish;
  end

  // Sender: predicts each accepted beat, then offers the next one after its gap.
  int         drv_wait = 0;
  text_beat_t drv_head;
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (rst_ni) begin
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        decode_beat(in_byte_i, in_last_i);
        items_in++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && send_q.size() != 0) begin
        if (send_q[0].drain) begin
          if (decoded_q.size() == 0) void'(send_q.pop_front());
        end else if (drv_wait < send_q[0].gap) begin
          drv_wait++;
        end else begin
          drv_head  = send_q.pop_front();
          drv_wait  = 0;
          in_byte_i <= drv_head.data;
          in_last_i <= drv_head.last;
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      errors++;
    end
  endtask

  // Receiver: checks each taken beat against the oldest expectation and
  // draws its own stall pattern, with one long hold-off.
  int          rx_wait   = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  plain_beat_t rx_want;
  always @(posedge clk_i) begin
    int rx_max;
    if (rst_ni) begin
      rx_max = ((beats_out / 40) % 3 == 1) ? 0 : 19;
      if (out_valid_o && !out_stall_i) begin
        beats_out++;
        if (decoded_q.size() == 0) begin
          $error("Decoded beat 0x%02h with no expectation waiting", out_byte_o);
          errors++;
        end else begin
          rx_want = decoded_q.pop_front();
          if (!rx_want.has_byte) markers++;
          check_field("out_byte", rx_want.data, out_byte_o);
          check_field("byte_valid", 8'(rx_want.has_byte), 8'(byte_valid_o));
          check_field("out_last", 8'(rx_want.last), 8'(out_last_o));
        end
        rx_wait = $urandom_range(0, rx_max);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      if (!hold_done && items_in >= HoldAtItem) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (rx_wait != 0) || (hold_left != 0);
    end
  end

endmodule
